// ===== rtl/dodc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the dag orientation degree counter
// no dependencies; used by dodc_ctrl, dodc_dp and the top level
package dodc_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = 16;
	localparam int EDGES_W   = 32;
	localparam int LIMIT_W   = 11;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [EDGES_W-1:0] EDGES_MAX = {EDGES_W{1'b1}};
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(MAX_NODES);

	// request kinds
	localparam logic REQ_EDGE  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SELF_LOOP = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_ORIENT = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [NODE_W-1:0]  edge_src;
		logic [NODE_W-1:0]  edge_dst;
		logic [CNT_W-1:0]   in_count;
		logic [CNT_W-1:0]   out_count;
		logic [CNT_W:0]     total_degree;
		logic [EDGES_W-1:0] edges_accepted;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              rd;
		logic              commit;
		logic              clr_wr;
		logic [NODE_W-1:0] clr_addr;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

// ===== rtl/dodc_ctrl.sv =====
`timescale 1ns / 1ps
// controller: clearing sweep after reset and per-beat read / write sequencing
// depends on dodc_pkg
module dodc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dodc_pkg::dp_sts_t  sts,
	output dodc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

	state_t                         state_q;
	logic [dodc_pkg::NODE_W-1:0]    clr_cnt_q;
	logic                           rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			rdy_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == dodc_pkg::NODE_W'(dodc_pkg::MAX_NODES - 1)) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_READ;
						rdy_q   <= 1'b0;
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
			endcase
		end
	end

	assign req_ready = rdy_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && req_valid;
		cmd.rd       = (state_q == S_READ);
		cmd.commit   = (state_q == S_WRITE) && !sts.out_busy;
		cmd.clr_wr   = (state_q == S_CLEAR);
		cmd.clr_addr = clr_cnt_q;
	end

endmodule

// ===== rtl/dodc_dp.sv =====
`timescale 1ns / 1ps
// datapath: orientation and range check, degree memories, edge total, result register
// depends on dodc_pkg
module dodc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dodc_pkg::dp_cmd_t             cmd,
	output dodc_pkg::dp_sts_t             sts,
	input  dodc_pkg::req_t                req,
	input  logic                          orient,
	input  logic [dodc_pkg::LIMIT_W-1:0]  node_limit,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output dodc_pkg::rsp_t                rsp
);

	localparam int NW = dodc_pkg::NODE_W;
	localparam int CW = dodc_pkg::CNT_W;

	logic [CW-1:0] out_mem [dodc_pkg::MAX_NODES];
	logic [CW-1:0] in_mem  [dodc_pkg::MAX_NODES];

	logic          swap, a_range, b_range;
	logic [NW-1:0] src_d, dst_d;
	logic [1:0]    status_d;

	logic          req_type_s1;
	logic [NW-1:0] node_a_s1, src_s1, dst_s1;
	logic [1:0]    status_s1;

	logic [CW-1:0] out_rd_s2, in_rd_s2;
	logic [NW-1:0] out_addr, in_addr;
	logic [CW-1:0] out_inc, in_inc;
	logic          wr_en, q_ok;

	logic [dodc_pkg::EDGES_W-1:0] total_q, total_d;
	logic                         rsp_valid_q;
	dodc_pkg::rsp_t               rsp_q, rsp_d;
	logic [CW-1:0]                ic, oc;

	// orientation and range check on the incoming beat
	always_comb begin
		swap     = orient && (req.node_a > req.node_b);
		src_d    = swap ? req.node_b : req.node_a;
		dst_d    = swap ? req.node_a : req.node_b;
		a_range  = {1'b0, req.node_a} >= node_limit;
		b_range  = {1'b0, req.node_b} >= node_limit;
		status_d = dodc_pkg::ST_OK;
		if (req.req_type == dodc_pkg::REQ_QUERY) begin
			if (a_range)
				status_d = dodc_pkg::ST_RANGE;
		end else begin
			priority if (a_range || b_range)
				status_d = dodc_pkg::ST_RANGE;
			else if (req.node_a == req.node_b)
				status_d = dodc_pkg::ST_SELF_LOOP;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_s1 <= req.req_type;
			node_a_s1   <= req.node_a;
			src_s1      <= src_d;
			dst_s1      <= dst_d;
			status_s1   <= status_d;
		end
	end

	assign out_addr = (req_type_s1 == dodc_pkg::REQ_QUERY) ? node_a_s1 : src_s1;
	assign in_addr  = (req_type_s1 == dodc_pkg::REQ_QUERY) ? node_a_s1 : dst_s1;

	assign wr_en   = cmd.commit && (req_type_s1 == dodc_pkg::REQ_EDGE)
	                 && (status_s1 == dodc_pkg::ST_OK);
	assign out_inc = (out_rd_s2 == dodc_pkg::CNT_MAX) ? out_rd_s2 : out_rd_s2 + 1'b1;
	assign in_inc  = (in_rd_s2 == dodc_pkg::CNT_MAX) ? in_rd_s2 : in_rd_s2 + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			out_mem[cmd.clr_addr] <= '0;
		else if (wr_en)
			out_mem[src_s1] <= out_inc;
		if (cmd.rd)
			out_rd_s2 <= out_mem[out_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			in_mem[cmd.clr_addr] <= '0;
		else if (wr_en)
			in_mem[dst_s1] <= in_inc;
		if (cmd.rd)
			in_rd_s2 <= in_mem[in_addr];
	end

	assign total_d = (wr_en && (total_q != dodc_pkg::EDGES_MAX)) ? total_q + 1'b1 : total_q;

	always_comb begin
		q_ok = (req_type_s1 == dodc_pkg::REQ_QUERY) && (status_s1 == dodc_pkg::ST_OK);
		ic   = q_ok ? in_rd_s2 : '0;
		oc   = q_ok ? out_rd_s2 : '0;
		rsp_d                = '0;
		rsp_d.status         = status_s1;
		rsp_d.edge_src       = (req_type_s1 == dodc_pkg::REQ_EDGE) ? src_s1 : '0;
		rsp_d.edge_dst       = (req_type_s1 == dodc_pkg::REQ_EDGE) ? dst_s1 : '0;
		rsp_d.in_count       = ic;
		rsp_d.out_count      = oc;
		rsp_d.total_degree   = {1'b0, ic} + {1'b0, oc};
		rsp_d.edges_accepted = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			total_q <= total_d;
			if (cmd.commit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			rsp_q <= rsp_d;
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

// ===== rtl/dag_orient_degree_counter.sv =====
`timescale 1ns / 1ps
// top level of the dag orientation degree counter: register port, controller, datapath
// depends on dodc_pkg, dodc_ctrl and dodc_dp
//
//  channel   signals                                 direction  beat
//  req       req_valid / req_ready / req (req_t)     in         one edge or one query
//  rsp       rsp_valid / rsp_ready / rsp (rsp_t)     out        one result per req beat
//  apb       psel penable pwrite paddr pwdata ...    in/out     one register access
//
// after reset a clearing sweep zeroes both degree memories, one entry a cycle,
//   with req_ready low; register writes are taken throughout
// each req beat then steps through accept, memory read, update and result
//   so a new beat is taken only once the previous beat has completed its update
// a result waiting in the output register holds the update cycle until it is taken
module dag_orient_degree_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  dodc_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output dodc_pkg::rsp_t                 rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dodc_pkg::ADDR_W-1:0]    paddr,
	input  logic [dodc_pkg::DATA_W-1:0]    pwdata,
	output logic [dodc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	// configuration registers
	logic                           orient_q;
	logic [dodc_pkg::LIMIT_W-1:0]   limit_q;
	logic                           wr_beat;

	dodc_pkg::dp_cmd_t cmd;
	dodc_pkg::dp_sts_t sts;

	assign pready  = 1'b1;
	assign wr_beat = psel && penable && pwrite;

	// register index sits in paddr[2]; the low byte-lane bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= 1'b0;
			limit_q  <= dodc_pkg::LIMIT_RST;
		end else if (wr_beat) begin
			unique case (paddr[2])
				dodc_pkg::REG_ORIENT: orient_q <= pwdata[0];
				dodc_pkg::REG_LIMIT:  limit_q  <= pwdata[dodc_pkg::LIMIT_W-1:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			dodc_pkg::REG_ORIENT: prdata = dodc_pkg::DATA_W'(orient_q);
			dodc_pkg::REG_LIMIT:  prdata = dodc_pkg::DATA_W'(limit_q);
		endcase
	end

	// sequencing: clearing sweep, accept, read, update
	dodc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// orientation, range check, degree memories and result register
	dodc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req        (req),
		.orient     (orient_q),
		.node_limit (limit_q),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

`ifndef SYNTHESIS
	// one beat in flight: ready drops right after an accepted beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted while a beat was still in flight");

	// a self-loop result always names the same node twice
	a_self_loop_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == dodc_pkg::ST_SELF_LOOP) |-> rsp.edge_src == rsp.edge_dst)
		else $error("self-loop status with distinct endpoints");

	// with orientation on, the source never exceeds the destination
	a_oriented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && orient_q |-> rsp.edge_src <= rsp.edge_dst)
		else $error("oriented edge has source above destination");

	// total degree is the sum of the two counts
	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.total_degree == ({1'b0, rsp.in_count} + {1'b0, rsp.out_count}))
		else $error("total degree does not match in and out counts");
`endif

endmodule
